### rtl/sjn_pkg.sv
// ----------------------------------------------------------------------------
// sjn_pkg
// Shared widths, table entry layout and the command/status bundles that run
// between the scheduler controller and its datapath.
// ----------------------------------------------------------------------------
package sjn_pkg;

   localparam int MAX_PROCS_DEF = 8;

   localparam int PRIO_W     = 8;   // process priority
   localparam int ARRIVAL_W  = 16;  // arrival time as loaded
   localparam int BURST_W    = 16;  // burst time as loaded
   localparam int TIME_W     = 20;  // scheduler clock, wraps
   localparam int START_W    = 19;  // reported start time
   localparam int WAIT_W     = 19;  // reported waiting time
   localparam int IDX_OUT_W  = 3;   // reported slot index

   typedef struct packed {
      logic [PRIO_W-1:0]    prio;
      logic [ARRIVAL_W-1:0] arrival;
      logic [BURST_W-1:0]   burst;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // store the accepted request transaction
      logic scan;    // issue one table read of the selection scan
      logic commit;  // fix the winner and advance the clock
      logic emit;    // move the finished result into the output register
   } sjn_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic close;      // request being offered closes the batch
      logic scan_last;  // read issued this cycle is the last of the scan
      logic out_free;   // output register can take a result this cycle
      logic last_pick;  // result being built is the last of the batch
   } sjn_status_type;

endpackage

### rtl/sjn_channel_if.sv
// ----------------------------------------------------------------------------
// sjn channel interfaces
// Valid/ready channels for the process request and the schedule result.
// ----------------------------------------------------------------------------
interface sjn_req_if;
   logic                            valid;
   logic                            ready;
   logic [sjn_pkg::PRIO_W-1:0]      priority_req;
   logic [sjn_pkg::ARRIVAL_W-1:0]   arrival_time;
   logic [sjn_pkg::BURST_W-1:0]     burst_time;
   logic                            last_process;

   modport source (output valid, priority_req, arrival_time, burst_time, last_process,
                   input ready);
   modport sink   (input valid, priority_req, arrival_time, burst_time, last_process,
                   output ready);
endinterface

interface sjn_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sjn_pkg::IDX_OUT_W-1:0]   process_index;
   logic [sjn_pkg::START_W-1:0]     start_time;
   logic [sjn_pkg::TIME_W-1:0]      finish_time;
   logic [sjn_pkg::TIME_W-1:0]      turnaround_time;
   logic [sjn_pkg::WAIT_W-1:0]      waiting_time;
   logic                            last_result;

   modport source (output valid, process_index, start_time, finish_time, turnaround_time,
                   waiting_time, last_result, input ready);
   modport sink   (input valid, process_index, start_time, finish_time, turnaround_time,
                   waiting_time, last_result, output ready);
endinterface

### rtl/sjn_datapath.sv
// ----------------------------------------------------------------------------
// sjn_datapath
// Process table, selection scan with two running winners, scheduler clock and
// the result output register.
// ----------------------------------------------------------------------------
module sjn_datapath #(
   parameter int MAX_PROCS = sjn_pkg::MAX_PROCS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sjn_pkg::sjn_cmd_type            cmd,
   output sjn_pkg::sjn_status_type         status,
   input  logic [sjn_pkg::PRIO_W-1:0]      req_priority,
   input  logic [sjn_pkg::ARRIVAL_W-1:0]   req_arrival,
   input  logic [sjn_pkg::BURST_W-1:0]     req_burst,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sjn_pkg::IDX_OUT_W-1:0]   rsp_index,
   output logic [sjn_pkg::START_W-1:0]     rsp_start,
   output logic [sjn_pkg::TIME_W-1:0]      rsp_finish,
   output logic [sjn_pkg::TIME_W-1:0]      rsp_turnaround,
   output logic [sjn_pkg::WAIT_W-1:0]      rsp_wait,
   output logic                            rsp_last
);

   localparam int IDX_W = $clog2(MAX_PROCS);
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int TW    = sjn_pkg::TIME_W;

   // process table
   sjn_pkg::entry_type entry_mem [MAX_PROCS];
   sjn_pkg::entry_type rd_entry_ff;

   // control state
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [IDX_W-1:0]     scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]     pick_cnt_ff, pick_cnt_in;
   logic [MAX_PROCS-1:0] done_ff, done_in;
   logic [TW-1:0]        cur_time_ff, cur_time_in;
   logic                 p_vld_ff, p_vld_in;
   logic                 fa_found_ff, fa_found_in;
   logic                 fe_found_ff, fe_found_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload
   logic [IDX_W-1:0]     p_idx_ff, p_idx_in;
   sjn_pkg::entry_type   fa_ent_ff, fa_ent_in;   // best among arrived
   logic [IDX_W-1:0]     fa_idx_ff, fa_idx_in;
   sjn_pkg::entry_type   fe_ent_ff, fe_ent_in;   // earliest undone
   logic [IDX_W-1:0]     fe_idx_ff, fe_idx_in;
   logic [IDX_W-1:0]     res_idx_ff, res_idx_in;
   logic [TW-1:0]        res_start_ff, res_start_in;
   logic [TW-1:0]        res_fin_ff, res_fin_in;
   logic [TW-1:0]        res_wait_ff, res_wait_in;
   logic [sjn_pkg::ARRIVAL_W-1:0] res_arr_ff, res_arr_in;
   logic [sjn_pkg::IDX_OUT_W-1:0] out_idx_ff, out_idx_in;
   logic [sjn_pkg::START_W-1:0]   out_start_ff, out_start_in;
   logic [TW-1:0]        out_fin_ff, out_fin_in;
   logic [TW-1:0]        out_turn_ff, out_turn_in;
   logic [sjn_pkg::WAIT_W-1:0]    out_wait_ff, out_wait_in;
   logic                 out_last_ff, out_last_in;

   // scan evaluation and commit helpers
   logic                 cand_done;
   logic                 cand_arrived;
   sjn_pkg::entry_type   sel_ent;
   logic [IDX_W-1:0]     sel_idx;
   logic [TW-1:0]        sel_start;
   logic                 close;
   logic                 last_pick;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         entry_mem[count_ff[IDX_W-1:0]] <= '{prio: req_priority, arrival: req_arrival,
                                            burst: req_burst};
      end
      rd_entry_ff <= entry_mem[scan_idx_ff];
   end

   assign close     = req_last || (count_ff == CNT_W'(MAX_PROCS - 1));
   assign last_pick = (pick_cnt_ff == n_ff - CNT_W'(1));

   assign cand_done    = done_ff[p_idx_ff];
   assign cand_arrived = !cand_done && (TW'(rd_entry_ff.arrival) <= cur_time_ff);

   // with no arrived process the clock idles to the earliest arrival, and the
   // earliest-arrival winner is then exactly the shortest-next winner
   assign sel_ent   = fa_found_ff ? fa_ent_ff : fe_ent_ff;
   assign sel_idx   = fa_found_ff ? fa_idx_ff : fe_idx_ff;
   assign sel_start = fa_found_ff ? cur_time_ff : TW'(fe_ent_ff.arrival);

   always_comb begin
      count_in     = count_ff;
      n_in         = n_ff;
      scan_idx_in  = scan_idx_ff;
      pick_cnt_in  = pick_cnt_ff;
      done_in      = done_ff;
      cur_time_in  = cur_time_ff;
      p_vld_in     = cmd.scan;
      p_idx_in     = scan_idx_ff;
      fa_found_in  = fa_found_ff;
      fe_found_in  = fe_found_ff;
      fa_ent_in    = fa_ent_ff;
      fa_idx_in    = fa_idx_ff;
      fe_ent_in    = fe_ent_ff;
      fe_idx_in    = fe_idx_ff;
      res_idx_in   = res_idx_ff;
      res_start_in = res_start_ff;
      res_fin_in   = res_fin_ff;
      res_wait_in  = res_wait_ff;
      res_arr_in   = res_arr_ff;
      out_idx_in   = out_idx_ff;
      out_start_in = out_start_ff;
      out_fin_in   = out_fin_ff;
      out_turn_in  = out_turn_ff;
      out_wait_in  = out_wait_ff;
      out_last_in  = out_last_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (cmd.load) begin
         done_in[count_ff[IDX_W-1:0]] = 1'b0;
         fa_found_in = 1'b0;
         fe_found_in = 1'b0;
         scan_idx_in = '0;
         if (close) begin
            count_in    = '0;
            n_in        = count_ff + CNT_W'(1);
            pick_cnt_in = '0;
            cur_time_in = '0;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end

      if (cmd.scan) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end

      // ascending scan with strict compares keeps the lower slot on a full tie
      if (p_vld_ff) begin
         if (cand_arrived && (!fa_found_ff ||
               {rd_entry_ff.burst, rd_entry_ff.prio, rd_entry_ff.arrival} <
               {fa_ent_ff.burst, fa_ent_ff.prio, fa_ent_ff.arrival})) begin
            fa_found_in = 1'b1;
            fa_ent_in   = rd_entry_ff;
            fa_idx_in   = p_idx_ff;
         end
         if (!cand_done && (!fe_found_ff ||
               {rd_entry_ff.arrival, rd_entry_ff.burst, rd_entry_ff.prio} <
               {fe_ent_ff.arrival, fe_ent_ff.burst, fe_ent_ff.prio})) begin
            fe_found_in = 1'b1;
            fe_ent_in   = rd_entry_ff;
            fe_idx_in   = p_idx_ff;
         end
      end

      if (cmd.commit) begin
         done_in[sel_idx] = 1'b1;
         res_idx_in       = sel_idx;
         res_start_in     = sel_start;
         res_fin_in       = sel_start + TW'(sel_ent.burst);
         res_wait_in      = sel_start - TW'(sel_ent.arrival);
         res_arr_in       = sel_ent.arrival;
         cur_time_in      = sel_start + TW'(sel_ent.burst);
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         out_idx_in   = sjn_pkg::IDX_OUT_W'(res_idx_ff);
         out_start_in = res_start_ff[sjn_pkg::START_W-1:0];
         out_fin_in   = res_fin_ff;
         out_turn_in  = res_fin_ff - TW'(res_arr_ff);
         out_wait_in  = res_wait_ff[sjn_pkg::WAIT_W-1:0];
         out_last_in  = last_pick;
         pick_cnt_in  = pick_cnt_ff + CNT_W'(1);
         fa_found_in  = 1'b0;
         fe_found_in  = 1'b0;
         scan_idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         n_ff         <= '0;
         scan_idx_ff  <= '0;
         pick_cnt_ff  <= '0;
         done_ff      <= '0;
         cur_time_ff  <= '0;
         p_vld_ff     <= 1'b0;
         fa_found_ff  <= 1'b0;
         fe_found_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         n_ff         <= n_in;
         scan_idx_ff  <= scan_idx_in;
         pick_cnt_ff  <= pick_cnt_in;
         done_ff      <= done_in;
         cur_time_ff  <= cur_time_in;
         p_vld_ff     <= p_vld_in;
         fa_found_ff  <= fa_found_in;
         fe_found_ff  <= fe_found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_idx_ff     <= p_idx_in;
      fa_ent_ff    <= fa_ent_in;
      fa_idx_ff    <= fa_idx_in;
      fe_ent_ff    <= fe_ent_in;
      fe_idx_ff    <= fe_idx_in;
      res_idx_ff   <= res_idx_in;
      res_start_ff <= res_start_in;
      res_fin_ff   <= res_fin_in;
      res_wait_ff  <= res_wait_in;
      res_arr_ff   <= res_arr_in;
      out_idx_ff   <= out_idx_in;
      out_start_ff <= out_start_in;
      out_fin_ff   <= out_fin_in;
      out_turn_ff  <= out_turn_in;
      out_wait_ff  <= out_wait_in;
      out_last_ff  <= out_last_in;
   end

   assign status.close     = close;
   assign status.scan_last = (CNT_W'(scan_idx_ff) == n_ff - CNT_W'(1));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign status.last_pick = last_pick;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_index      = out_idx_ff;
   assign rsp_start      = out_start_ff;
   assign rsp_finish     = out_fin_ff;
   assign rsp_turnaround = out_turn_ff;
   assign rsp_wait       = out_wait_ff;
   assign rsp_last       = out_last_ff;

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result moved into an occupied output register");

   a_commit_has_winner: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (fa_found_ff || fe_found_ff))
      else $error("commit without any undone process");

   a_commit_marks_done: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> done_ff[res_idx_ff])
      else $error("scheduled process not marked done");

   a_load_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (count_ff < CNT_W'(MAX_PROCS)))
      else $error("load beyond the table");

   a_scan_in_batch: assert property (@(posedge clock) disable iff (reset)
      p_vld_ff |-> (CNT_W'(p_idx_ff) < n_ff))
      else $error("scan read outside the loaded batch");

endmodule

### rtl/sjn_ctrl.sv
// ----------------------------------------------------------------------------
// sjn_ctrl
// Sequencer: load the batch, then for each process scan the table, commit the
// winner and hand the result to the output register.
// ----------------------------------------------------------------------------
module sjn_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sjn_pkg::sjn_status_type status,
   output sjn_pkg::sjn_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_LOAD   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_COMMIT = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.close) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last table read is evaluated this cycle
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.last_pick ? ST_LOAD : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/shortest_job_next_scheduler.sv
// ----------------------------------------------------------------------------
// shortest_job_next_scheduler
// Non-preemptive shortest-process-next scheduler over a batch of processes.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus takes one process per transaction (priority, arrival, burst,
//   last_process); each is stored in the next table slot, and the slot number
//   names the process. A transaction with last_process set, or the one that
//   fills slot MAX_PROCS-1, closes the batch.
//   rsp_bus then delivers one transaction per process in run order, with
//   start, finish, turnaround and waiting time; last_result marks the end.
//   For each result the table is read once per slot through a single read
//   port, the last read is compared, the winner is committed and then it is
//   moved into the output register.
//   No new process is taken while a batch is being scheduled; loading resumes
//   as soon as the last result sits in the output register.
//   A stalled rsp_bus holds the output register; scheduling continues up to
//   the next result and waits there.
//   Reset empties the table and the output register; no clearing pass.
// ----------------------------------------------------------------------------
module shortest_job_next_scheduler #(
   parameter int MAX_PROCS = sjn_pkg::MAX_PROCS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sjn_req_if.sink   req_bus,
   sjn_rsp_if.source rsp_bus
);

   sjn_pkg::sjn_cmd_type    cmd;
   sjn_pkg::sjn_status_type status;
   logic                    req_ready;

   sjn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sjn_datapath #(
      .MAX_PROCS (MAX_PROCS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_priority   (req_bus.priority_req),
      .req_arrival    (req_bus.arrival_time),
      .req_burst      (req_bus.burst_time),
      .req_last       (req_bus.last_process),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_index      (rsp_bus.process_index),
      .rsp_start      (rsp_bus.start_time),
      .rsp_finish     (rsp_bus.finish_time),
      .rsp_turnaround (rsp_bus.turnaround_time),
      .rsp_wait       (rsp_bus.waiting_time),
      .rsp_last       (rsp_bus.last_result)
   );

   assign req_bus.ready = req_ready;

endmodule

### bench/shortest_job_next_scheduler_tb.sv
// ----------------------------------------------------------------------------
// shortest_job_next_scheduler_tb
// Self-checking bench for the shortest-job-next scheduler. Batches of
// processes go in over req_bus while a local scheduler predicts the run order
// and timing of each batch. Every rsp_bus transaction is checked against the
// oldest prediction. Both channels idle at random, the receiver holds off once
// for a long stretch, and a watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module shortest_job_next_scheduler_tb;

   localparam int MAX_PROCS      = sjn_pkg::MAX_PROCS_DEF;
   localparam int PRIO_W         = sjn_pkg::PRIO_W;
   localparam int ARRIVAL_W      = sjn_pkg::ARRIVAL_W;
   localparam int BURST_W        = sjn_pkg::BURST_W;
   localparam int TIME_W         = sjn_pkg::TIME_W;
   localparam int START_W        = sjn_pkg::START_W;
   localparam int WAIT_W         = sjn_pkg::WAIT_W;
   localparam int IDX_OUT_W      = sjn_pkg::IDX_OUT_W;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_ITEMS   = 100;
   localparam int END_WAIT       = 30;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] slot;
      logic [START_W-1:0]   start_at;
      logic [TIME_W-1:0]    finish_at;
      logic [TIME_W-1:0]    turnaround;
      logic [WAIT_W-1:0]    waited;
      logic                 batch_end;
   } run_record_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sjn_req_if req_bus ();
   sjn_rsp_if rsp_bus ();

   shortest_job_next_scheduler #(.MAX_PROCS(MAX_PROCS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #6 clock = ~clock;

   // local copy of the process table
   logic [PRIO_W-1:0]    prio_tab    [MAX_PROCS];
   logic [ARRIVAL_W-1:0] arrival_tab [MAX_PROCS];
   logic [BURST_W-1:0]   burst_tab   [MAX_PROCS];
   int unsigned          loaded_procs = 0;

   run_record_type expected_runs [$];

   int  mismatches      = 0;
   int  results_checked = 0;
   int  procs_sent      = 0;
   int  batches_closed  = 0;
   int  stalled_cycles  = 0;
   bit  no_idle         = 1'b0;
   bit  hold_request    = 1'b0;

   // ---------------------------------------------------------------- predictor
   function automatic bit runs_ahead(int a, int b);
      if (burst_tab[a] != burst_tab[b]) return burst_tab[a] < burst_tab[b];
      if (prio_tab[a] != prio_tab[b]) return prio_tab[a] < prio_tab[b];
      if (arrival_tab[a] != arrival_tab[b]) return arrival_tab[a] < arrival_tab[b];
      return a < b;
   endfunction

   function automatic void schedule_batch();
      bit                picked [MAX_PROCS];
      logic [TIME_W-1:0] clock_now;
      logic [TIME_W-1:0] finish;
      logic [TIME_W-1:0] turn;
      logic [31:0]       earliest;
      bit                any_ready;
      int                winner;
      run_record_type    rec;
      clock_now = '0;
      for (int i = 0; i < MAX_PROCS; i++) picked[i] = 1'b0;
      for (int k = 0; k < int'(loaded_procs); k++) begin
         any_ready = 1'b0;
         for (int i = 0; i < int'(loaded_procs); i++)
            if (!picked[i] && arrival_tab[i] <= clock_now) any_ready = 1'b1;
         // nobody has arrived: idle forward to the next arrival
         if (!any_ready) begin
            earliest = 32'hFFFF_FFFF;
            for (int i = 0; i < int'(loaded_procs); i++)
               if (!picked[i] && arrival_tab[i] < earliest) earliest = arrival_tab[i];
            clock_now = earliest[TIME_W-1:0];
         end
         winner = -1;
         for (int i = 0; i < int'(loaded_procs); i++) begin
            if (picked[i] || arrival_tab[i] > clock_now) continue;
            if (winner < 0 || runs_ahead(i, winner)) winner = i;
         end
         picked[winner] = 1'b1;
         finish = clock_now + TIME_W'(burst_tab[winner]);
         turn   = finish - TIME_W'(arrival_tab[winner]);
         rec.slot       = IDX_OUT_W'(winner);
         rec.start_at   = clock_now[START_W-1:0];
         rec.finish_at  = finish;
         rec.turnaround = turn;
         rec.waited     = WAIT_W'(turn - TIME_W'(burst_tab[winner]));
         rec.batch_end  = (k + 1 == int'(loaded_procs));
         expected_runs.push_back(rec);
         clock_now = finish;
      end
      loaded_procs = 0;
      batches_closed++;
   endfunction

   function automatic void store_process(logic [PRIO_W-1:0] prio, logic [ARRIVAL_W-1:0] arr,
                                         logic [BURST_W-1:0] burst, logic closes);
      prio_tab[loaded_procs]    = prio;
      arrival_tab[loaded_procs] = arr;
      burst_tab[loaded_procs]   = burst;
      loaded_procs++;
      if (closes || loaded_procs == MAX_PROCS) schedule_batch();
   endfunction

   // ---------------------------------------------------------------- idling
   function automatic int idle_length();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic sender_gap();
      int gap;
      if (no_idle || $urandom_range(0, 9) > 2) return;
      gap = idle_length();
      @(negedge clock);
      req_bus.valid = 1'b0;
      repeat (gap - 1) @(negedge clock);
   endtask

   // valid stays high between back-to-back transactions; only a gap or a drain wait lowers it
   task automatic send_process(logic [PRIO_W-1:0] prio, logic [ARRIVAL_W-1:0] arr,
                               logic [BURST_W-1:0] burst, logic closes);
      @(negedge clock);
      req_bus.priority_req = prio;
      req_bus.arrival_time = arr;
      req_bus.burst_time   = burst;
      req_bus.last_process = closes;
      req_bus.valid        = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      store_process(prio, arr, burst, closes);
      procs_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_runs.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_value(int mode);
      case (mode)
         0: return 16'($urandom_range(0, 7));
         1: return 16'($urandom_range(0, 300));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // ---------------------------------------------------------------- receiver
   initial begin : rsp_ready_driver
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            stall = idle_length();
            rsp_bus.ready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- checking
   always @(posedge clock) begin : result_checker
      run_record_type want;
      run_record_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.slot       = rsp_bus.process_index;
         got.start_at   = rsp_bus.start_time;
         got.finish_at  = rsp_bus.finish_time;
         got.turnaround = rsp_bus.turnaround_time;
         got.waited     = rsp_bus.waiting_time;
         got.batch_end  = rsp_bus.last_result;
         if (expected_runs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: slot %0d start %0d finish %0d",
                        got.slot, got.start_at, got.finish_at);
         end else begin
            want = expected_runs.pop_front();
            results_checked++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp slot %0d start %0d finish %0d turn %0d wait %0d ",
                            "last %0b / got slot %0d start %0d finish %0d turn %0d wait %0d ",
                            "last %0b"},
                           want.slot, want.start_at, want.finish_at, want.turnaround,
                           want.waited, want.batch_end, got.slot, got.start_at,
                           got.finish_at, got.turnaround, got.waited, got.batch_end);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stalled_cycles <= 0;
      else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles without a transaction", stalled_cycles);
         $display("shortest_job_next_scheduler_tb: FAIL");
         $finish;
      end else
         stalled_cycles <= stalled_cycles + 1;
   end

   // ---------------------------------------------------------------- tests
   task automatic test_single_extremes();
      send_process(8'd0, 16'd0, 16'd0, 1'b1);
      sender_gap();
      // lone process arriving late: clock idles up to it
      send_process(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
      sender_gap();
   endtask

   task automatic test_tie_breaks();
      send_process(8'd2, 16'd1, 16'd10, 1'b0);
      send_process(8'd2, 16'd0, 16'd10, 1'b0);
      send_process(8'd2, 16'd0, 16'd10, 1'b0);
      send_process(8'd0, 16'd3, 16'd10, 1'b0);
      send_process(8'd5, 16'd0, 16'd10, 1'b0);
      send_process(8'd9, 16'd0, 16'd4, 1'b1);
      sender_gap();
   endtask

   task automatic test_idle_gaps();
      send_process(8'd1, 16'd1000, 16'd5, 1'b0);
      send_process(8'd1, 16'd40000, 16'd0, 1'b0);
      send_process(8'd0, 16'd20, 16'd3, 1'b1);
      sender_gap();
   endtask

   // eight processes close the batch with last_process low
   task automatic test_full_table();
      for (int i = 0; i < MAX_PROCS; i++)
         send_process(8'(255 - i), (i == MAX_PROCS - 1) ? 16'hFFFF : 16'd0, 16'hFFFF, 1'b0);
      sender_gap();
   endtask

   task automatic test_output_stall();
      wait_drained();
      hold_request = 1'b1;
      for (int i = 0; i < MAX_PROCS; i++)
         send_process(8'($urandom_range(0, 255)), pick_value(2), pick_value(2), 1'b0);
      // next batch backs up behind the held results
      for (int i = 0; i < 3; i++)
         send_process(8'($urandom_range(0, 255)), pick_value(1), pick_value(1), i == 2);
      wait_drained();
   endtask

   task automatic test_random_batches();
      int sent;
      int size;
      int shape;
      int arr_mode;
      int burst_mode;
      int prio_mode;
      logic closes;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         no_idle    = (sent < 30);
         shape      = $urandom_range(0, 9);
         size       = (shape < 6) ? $urandom_range(1, MAX_PROCS) :
                      (shape < 8) ? MAX_PROCS : $urandom_range(1, 3);
         arr_mode   = $urandom_range(0, 2);
         burst_mode = $urandom_range(0, 2);
         prio_mode  = $urandom_range(0, 1);
         for (int i = 0; i < size; i++) begin
            // a batch drawn as full (shape 6 or 7) is left to close itself on the last slot
            closes = (i == size - 1) && (shape < 6 || shape >= 8);
            send_process(prio_mode ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3)),
                         pick_value(arr_mode), pick_value(burst_mode), closes);
            sender_gap();
            sent++;
         end
         if ($urandom_range(0, 9) == 0) wait_drained();
      end
      no_idle = 1'b0;
   endtask

   initial begin : run_tests
      req_bus.valid        = 1'b0;
      req_bus.priority_req = '0;
      req_bus.arrival_time = '0;
      req_bus.burst_time   = '0;
      req_bus.last_process = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_single_extremes();
      test_tie_breaks();
      test_idle_gaps();
      test_full_table();
      test_output_stall();
      test_random_batches();

      wait_drained();
      repeat (END_WAIT) @(posedge clock);

      $display("covered %0d processes in %0d batches, incl. ties, idle gaps, full tables",
               procs_sent, batches_closed);
      $display("checked %0d scheduled results, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0 && expected_runs.size() == 0)
         $display("shortest_job_next_scheduler_tb: PASS");
      else
         $display("shortest_job_next_scheduler_tb: FAIL");
      $finish;
   end

endmodule

### files.f
rtl/sjn_pkg.sv
rtl/sjn_channel_if.sv
rtl/sjn_datapath.sv
rtl/sjn_ctrl.sv
rtl/shortest_job_next_scheduler.sv
bench/shortest_job_next_scheduler_tb.sv
